FILE: design/running_column_entropy_defines.svh
// Assertion macros shared by the RTL of the running column entropy block.
`ifndef RUNNING_COLUMN_ENTROPY_DEFINES_SVH
`define RUNNING_COLUMN_ENTROPY_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define RCE_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define RCE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define RCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RCE_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`define RCE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define RCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/rce_pkg.sv
`default_nettype none

package rce_pkg;

   localparam int IN_FIELDS           = 6;
   localparam int NUM_COLUMNS_DEFAULT = 6;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 16;

   // Counts never pass 65535, so a count and the row counter are 16 bits.
   localparam int CNT_W    = 16;
   localparam int ROW_CAP  = 65535;
   localparam int FRAC_W   = 32;
   localparam int K_W      = 4;
   localparam int STEP_W   = 5;
   // c*log2(c) with 32 fraction bits stays below 2^52 for c below 2^16.
   localparam int CLOGC_W  = 52;
   localparam int NUM_W    = 53;
   localparam int Q_W      = 21;
   localparam int Q_TOP    = Q_W - 1;
   localparam logic [Q_W-1:0] ENTROPY_MAX = Q_W'(16 << 16);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN
   } top_state_type;

   typedef enum logic [2:0] {
      LN_IDLE,
      LN_READ,
      LN_LOG_OLD,
      LN_LOG_NEW,
      LN_WAIT_TOT,
      LN_DIV,
      LN_DONE
   } lane_state_type;

   typedef enum logic [1:0] {
      CL_IDLE,
      CL_SQUARE,
      CL_SCALE
   } clogc_state_type;

   typedef struct packed {
      logic start;
      logic update;
      logic total_valid;
      logic clear_en;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: design/rce_clogc.sv
`default_nettype none

// Computes x*log2(x) with 32 fraction bits. The fraction comes from 32
// repeated squarings of the normalized mantissa, one squaring a cycle.
module rce_clogc (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rce_pkg::CNT_W-1:0]   x,
   output logic                              done,
   output logic [rce_pkg::CLOGC_W-1:0]      result
);

   rce_pkg::clogc_state_type state_ff, state_in;
   logic [rce_pkg::CNT_W-1:0]   x_ff, x_in;
   logic [rce_pkg::K_W-1:0]     k_ff, k_in;
   logic [rce_pkg::FRAC_W-1:0]  m_ff, m_in;
   logic [rce_pkg::FRAC_W-1:0]  frac_ff, frac_in;
   logic [rce_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        done_ff, done_in;
   logic [rce_pkg::CLOGC_W-1:0] result_ff, result_in;

   logic [rce_pkg::K_W-1:0]       msb;
   logic [2*rce_pkg::FRAC_W-1:0]  square;
   logic [rce_pkg::FRAC_W:0]      sq;

   always_comb begin
      msb = '0;
      for (int i = 0; i < rce_pkg::CNT_W; i++) begin
         if (x[i]) begin
            msb = rce_pkg::K_W'(i);
         end
      end
   end

   assign square = (2*rce_pkg::FRAC_W)'(m_ff) * (2*rce_pkg::FRAC_W)'(m_ff);
   assign sq     = square[2*rce_pkg::FRAC_W-1:rce_pkg::FRAC_W-1];

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (state_ff)
         rce_pkg::CL_IDLE: begin
            if (start) begin
               x_in     = x;
               k_in     = msb;
               // A zero input gives a zero mantissa, so the result is zero.
               m_in     = rce_pkg::FRAC_W'(x) << (rce_pkg::STEP_W'(rce_pkg::FRAC_W - 1)
                          - rce_pkg::STEP_W'(msb));
               frac_in  = '0;
               step_in  = rce_pkg::STEP_W'(rce_pkg::FRAC_W - 1);
               state_in = rce_pkg::CL_SQUARE;
            end
         end
         rce_pkg::CL_SQUARE: begin
            m_in = sq[rce_pkg::FRAC_W] ? sq[rce_pkg::FRAC_W:1] : sq[rce_pkg::FRAC_W-1:0];
            frac_in[step_ff] = sq[rce_pkg::FRAC_W];
            if (step_ff == '0) begin
               state_in = rce_pkg::CL_SCALE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         rce_pkg::CL_SCALE: begin
            result_in = (rce_pkg::CLOGC_W'(20'(x_ff) * 20'(k_ff)) << rce_pkg::FRAC_W)
                      + rce_pkg::CLOGC_W'(48'(x_ff) * 48'(frac_ff));
            done_in   = 1'b1;
            state_in  = rce_pkg::CL_IDLE;
         end
         default: begin
            state_in = rce_pkg::CL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rce_pkg::CL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff      <= x_in;
      k_ff      <= k_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

FILE: design/rce_lane.sv
`default_nettype none

// One column: its histogram memory, its running sum of c*log2(c) and a
// bit-per-cycle divider that turns the sum into the entropy.
module rce_lane #(
   parameter int SAMPLE_BITS = rce_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rce_pkg::lane_ctrl_type        ctrl,
   input  wire logic [SAMPLE_BITS-1:0]        sample,
   input  wire logic [SAMPLE_BITS-1:0]        clear_addr,
   input  wire logic [rce_pkg::CNT_W-1:0]     rows,
   input  wire logic [rce_pkg::CLOGC_W-1:0]   total,
   output logic                               done,
   output logic [rce_pkg::Q_W-1:0]            entropy
);

   localparam int BINS = 1 << SAMPLE_BITS;

   logic [rce_pkg::CNT_W-1:0] mem [BINS];

   rce_pkg::lane_state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0]      addr_ff, addr_in;
   logic [rce_pkg::CNT_W-1:0]   rd_ff;
   logic [rce_pkg::CLOGC_W-1:0] old_ff, old_in;
   logic [rce_pkg::CLOGC_W-1:0] sum_ff, sum_in;
   logic [rce_pkg::NUM_W-1:0]   rem_ff, rem_in;
   logic [rce_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [rce_pkg::Q_W-1:0]     q_ff, q_in;
   logic [rce_pkg::Q_W-1:0]     ent_ff, ent_in;

   logic                        rd_en;
   logic                        wr_en;
   logic [SAMPLE_BITS-1:0]      wr_addr;
   logic [rce_pkg::CNT_W-1:0]   wr_data;
   logic [rce_pkg::CNT_W-1:0]   count_next;
   logic                        cl_start;
   logic [rce_pkg::CNT_W-1:0]   cl_x;
   logic                        cl_done;
   logic [rce_pkg::CLOGC_W-1:0] cl_result;
   logic [rce_pkg::NUM_W-1:0]   divisor;

   rce_clogc u_clogc (
      .clock  (clock),
      .reset  (reset),
      .start  (cl_start),
      .x      (cl_x),
      .done   (cl_done),
      .result (cl_result)
   );

   assign count_next = rd_ff + 1'b1;
   assign cl_x       = (state_ff == rce_pkg::LN_READ) ? rd_ff : count_next;
   assign rd_en      = ctrl.start & ctrl.update;
   assign wr_en      = ctrl.clear_en | ((state_ff == rce_pkg::LN_LOG_NEW) & cl_done);
   assign wr_addr    = ctrl.clear_en ? clear_addr : addr_ff;
   assign wr_data    = ctrl.clear_en ? '0 : count_next;
   assign divisor    = (rce_pkg::NUM_W'(rows) << 16) << step_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[sample];
      end
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      old_in   = old_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      q_in     = q_ff;
      ent_in   = ent_ff;
      cl_start = 1'b0;
      case (state_ff)
         rce_pkg::LN_IDLE, rce_pkg::LN_DONE: begin
            if (ctrl.start) begin
               addr_in  = sample;
               state_in = ctrl.update ? rce_pkg::LN_READ : rce_pkg::LN_WAIT_TOT;
            end
         end
         rce_pkg::LN_READ: begin
            cl_start = 1'b1;
            state_in = rce_pkg::LN_LOG_OLD;
         end
         rce_pkg::LN_LOG_OLD: begin
            if (cl_done) begin
               old_in   = cl_result;
               cl_start = 1'b1;
               state_in = rce_pkg::LN_LOG_NEW;
            end
         end
         rce_pkg::LN_LOG_NEW: begin
            if (cl_done) begin
               sum_in   = sum_ff - old_ff + cl_result;
               state_in = rce_pkg::LN_WAIT_TOT;
            end
         end
         rce_pkg::LN_WAIT_TOT: begin
            if (ctrl.total_valid) begin
               if (rows == '0 || sum_ff >= total) begin
                  ent_in   = '0;
                  state_in = rce_pkg::LN_DONE;
               end else begin
                  // Adding half the divisor makes the quotient round half up.
                  rem_in   = rce_pkg::NUM_W'(total - sum_ff) + (rce_pkg::NUM_W'(rows) << 15);
                  step_in  = rce_pkg::STEP_W'(rce_pkg::Q_TOP);
                  q_in     = '0;
                  state_in = rce_pkg::LN_DIV;
               end
            end
         end
         rce_pkg::LN_DIV: begin
            if (rem_ff >= divisor) begin
               rem_in        = rem_ff - divisor;
               q_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               ent_in   = (q_in > rce_pkg::ENTROPY_MAX) ? rce_pkg::ENTROPY_MAX : q_in;
               state_in = rce_pkg::LN_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            state_in = rce_pkg::LN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rce_pkg::LN_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
      addr_ff <= addr_in;
      old_ff  <= old_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      ent_ff  <= ent_in;
   end

   assign done    = (state_ff == rce_pkg::LN_DONE);
   assign entropy = ent_ff;

endmodule

`default_nettype wire

FILE: design/running_column_entropy.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     req_sample_col0 .. req_sample_col5
// rsp       out        rsp_valid/stall     rsp_row_index, rsp_saturated, rsp_entropy_col0..5
//
// Histograms are cleared after reset, one bin a cycle, all 2^SAMPLE_BITS bins.
// Per column a result takes a bin read, two c*log2(c) runs and a divide; a
// saturated item skips the read and the runs and waits for n*log2(n) only.
// The input is free again in the cycle after the result is loaded.
// A result waits in the output register; a stalled rsp side holds back the
// next result and, once that one is done, the input.
`default_nettype none

module running_column_entropy #(
   parameter int NUM_COLUMNS = rce_pkg::NUM_COLUMNS_DEFAULT,
   parameter int SAMPLE_BITS = rce_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = rce_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [15:0]         req_sample_col0,
   input  wire logic signed [15:0]         req_sample_col1,
   input  wire logic signed [15:0]         req_sample_col2,
   input  wire logic signed [15:0]         req_sample_col3,
   input  wire logic signed [15:0]         req_sample_col4,
   input  wire logic signed [15:0]         req_sample_col5,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [15:0]                     rsp_row_index,
   output logic                            rsp_saturated,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col0,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col1,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col2,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col3,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col4,
   output logic [rce_pkg::Q_W-1:0]         rsp_entropy_col5
);

   `include "running_column_entropy_defines.svh"

   localparam int LANES      = (NUM_COLUMNS < rce_pkg::IN_FIELDS) ? NUM_COLUMNS
                                                                  : rce_pkg::IN_FIELDS;
   localparam int COUNT_FULL = (1 << COUNT_BITS) - 1;
   localparam int ROW_MAX_I  = (COUNT_FULL < rce_pkg::ROW_CAP) ? COUNT_FULL : rce_pkg::ROW_CAP;
   localparam logic [rce_pkg::CNT_W-1:0] ROW_MAX  = rce_pkg::CNT_W'(ROW_MAX_I);
   localparam logic [rce_pkg::CNT_W-1:0] ROW_LAST = rce_pkg::CNT_W'(ROW_MAX_I - 1);

   rce_pkg::top_state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0]      clear_addr_ff, clear_addr_in;
   logic [rce_pkg::CNT_W-1:0]   rows_ff, rows_in;
   logic                        full_ff, full_in;
   logic [rce_pkg::CLOGC_W-1:0] total_ff, total_in;
   logic                        total_valid_ff, total_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                 row_index_ff, row_index_in;
   logic                        saturated_ff, saturated_in;
   logic [rce_pkg::Q_W-1:0]     ent_ff [rce_pkg::IN_FIELDS];
   logic [rce_pkg::Q_W-1:0]     ent_in [rce_pkg::IN_FIELDS];

   logic [15:0]                 samples [rce_pkg::IN_FIELDS];
   logic [LANES-1:0]            lane_done;
   logic [rce_pkg::Q_W-1:0]     lane_ent [LANES];
   rce_pkg::lane_ctrl_type      lane_ctrl;
   logic                        accept;
   logic                        full_now;
   logic [rce_pkg::CNT_W-1:0]   n_next;
   logic                        tot_done;
   logic [rce_pkg::CLOGC_W-1:0] tot_result;
   logic                        out_free;
   logic                        all_done;
   logic                        load;

   assign samples[0] = req_sample_col0;
   assign samples[1] = req_sample_col1;
   assign samples[2] = req_sample_col2;
   assign samples[3] = req_sample_col3;
   assign samples[4] = req_sample_col4;
   assign samples[5] = req_sample_col5;

   assign req_stall = (state_ff != rce_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign full_now  = (rows_ff >= ROW_MAX);
   assign n_next    = full_now ? rows_ff : rows_ff + 1'b1;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign all_done  = (&lane_done) & total_valid_ff;
   assign load      = (state_ff == rce_pkg::ST_RUN) & all_done & out_free;

   assign lane_ctrl.start       = accept;
   assign lane_ctrl.update      = ~full_now;
   assign lane_ctrl.total_valid = total_valid_ff;
   assign lane_ctrl.clear_en    = (state_ff == rce_pkg::ST_CLEAR);

   // n*log2(n) for the row count as it stands after this item.
   rce_clogc u_total (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .x      (n_next),
      .done   (tot_done),
      .result (tot_result)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rce_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .sample     (samples[g][SAMPLE_BITS-1:0]),
         .clear_addr (clear_addr_ff),
         .rows       (rows_ff),
         .total      (total_ff),
         .done       (lane_done[g]),
         .entropy    (lane_ent[g])
      );
   end

   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      rows_in        = rows_ff;
      full_in        = full_ff;
      total_in       = total_ff;
      total_valid_in = total_valid_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      row_index_in   = row_index_ff;
      saturated_in   = saturated_ff;
      for (int i = 0; i < rce_pkg::IN_FIELDS; i++) begin
         ent_in[i] = ent_ff[i];
      end
      if (tot_done) begin
         total_in       = tot_result;
         total_valid_in = 1'b1;
      end
      case (state_ff)
         rce_pkg::ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (&clear_addr_ff) begin
               state_in = rce_pkg::ST_IDLE;
            end
         end
         rce_pkg::ST_IDLE: begin
            if (accept) begin
               full_in        = full_now;
               rows_in        = n_next;
               total_valid_in = 1'b0;
               state_in       = rce_pkg::ST_RUN;
            end
         end
         rce_pkg::ST_RUN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               saturated_in = full_ff;
               row_index_in = full_ff ? ROW_LAST : rows_ff - 1'b1;
               for (int i = 0; i < rce_pkg::IN_FIELDS; i++) begin
                  ent_in[i] = (i < LANES) ? lane_ent[i] : '0;
               end
               state_in = rce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rce_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rce_pkg::ST_CLEAR;
         clear_addr_ff  <= '0;
         rows_ff        <= '0;
         total_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         rows_ff        <= rows_in;
         total_valid_ff <= total_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      full_ff      <= full_in;
      total_ff     <= total_in;
      row_index_ff <= row_index_in;
      saturated_ff <= saturated_in;
      for (int i = 0; i < rce_pkg::IN_FIELDS; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = row_index_ff;
   assign rsp_saturated    = saturated_ff;
   assign rsp_entropy_col0 = ent_ff[0];
   assign rsp_entropy_col1 = ent_ff[1];
   assign rsp_entropy_col2 = ent_ff[2];
   assign rsp_entropy_col3 = ent_ff[3];
   assign rsp_entropy_col4 = ent_ff[4];
   assign rsp_entropy_col5 = ent_ff[5];

   `RCE_ASSERT_NEVER(a_rows_cap, clock, reset, rows_ff > ROW_MAX,
      "row count passed its cap")
   `RCE_ASSERT_SAME(a_sat_index, clock, reset, rsp_valid_ff && saturated_ff,
      row_index_ff == ROW_LAST, "saturated item with wrong row index")
   `RCE_ASSERT_NEXT(a_accept_run, clock, reset, accept,
      state_ff == rce_pkg::ST_RUN && !total_valid_ff, "accepted item did not start a run")
   `RCE_ASSERT_SAME(a_clear_quiet, clock, reset, state_ff == rce_pkg::ST_CLEAR,
      !rsp_valid_ff && rows_ff == '0, "activity during histogram clear")

endmodule

`default_nettype wire
